>>> sv/assert_macros.svh
// Assertion helpers, included by the RTL that checks its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same-cycle implication between two conditions.
`define ASSERT_IMP(lbl, ante, cons, msg) \
	`ASSERT_CLK(lbl, (ante) |-> (cons), msg)

`endif

>>> sv/rtic_pkg.sv
`default_nettype none

package rtic_pkg;

	// Configuration register map.
	localparam int CFG_IDX_W = 8;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW0_AB  = 8'd0,
		REG_ROW0_CD  = 8'd1,
		REG_ROW1_AB  = 8'd2,
		REG_ROW1_CD  = 8'd3,
		REG_ROW2_AB  = 8'd4,
		REG_ROW2_CD  = 8'd5,
		REG_NORMAL_XY = 8'd6,
		REG_NORMAL_Z = 8'd7
	} cfg_reg_t;

	// Pipeline depths.
	localparam int FPU_LAT   = 3;
	localparam int DIV_STEPS = 27;
	localparam int DIV_PAD   = 48 - DIV_STEPS - 1;
	localparam int DIV_LAT   = DIV_STEPS + 3;
	localparam int T_DZ      = 3 * FPU_LAT;
	localparam int T_OZ      = 4 * FPU_LAT;
	localparam int T_T       = T_OZ + DIV_LAT;
	localparam int T_F       = T_T + 8 * FPU_LAT;

	localparam logic [31:0] FP_ZERO = 32'h0000_0000;
	localparam logic [31:0] FP_ONE  = 32'h3F80_0000;
	localparam logic [31:0] FP_QNAN = 32'h7FC0_0000;

	typedef enum logic {
		FOP_ADD,
		FOP_MUL
	} fop_t;

	typedef struct packed {
		logic [31:0] origin_x;
		logic [31:0] origin_y;
		logic [31:0] origin_z;
		logic [31:0] dir_x;
		logic [31:0] dir_y;
		logic [31:0] dir_z;
		logic [31:0] t_max;
	} ray_req_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] t_hit;
		logic [31:0] point_x;
		logic [31:0] point_y;
		logic [31:0] point_z;
		logic [31:0] bary_u;
		logic [31:0] bary_v;
		logic        back_face;
	} hit_rsp_t;

	// Unpacked operand: subnormals get exponent 1 and no hidden bit.
	typedef struct packed {
		logic        sign;
		logic        is_nan;
		logic        is_inf;
		logic        is_zero;
		logic [7:0]  exp;
		logic [23:0] mant;
	} fp_unp_t;

	// Unrounded result: value = sig * 2^(exp - 127 - 47).
	typedef struct packed {
		logic               sign;
		logic               is_nan;
		logic               is_inf;
		logic signed [10:0] exp;
		logic [47:0]        sig;
	} fp_raw_t;

	function automatic fp_unp_t fp_unpack(input logic [31:0] b);
		fp_unp_t r;
		r.sign    = b[31];
		r.is_nan  = (&b[30:23]) & (|b[22:0]);
		r.is_inf  = (&b[30:23]) & ~(|b[22:0]);
		r.is_zero = ~(|b[30:0]);
		r.exp     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
		r.mant    = {|b[30:23], b[22:0]};
		return r;
	endfunction

	// Shift the leading one up to bit 47.
	function automatic fp_raw_t fp_normalize(input fp_raw_t a);
		fp_raw_t r;
		logic [5:0] lz;
		lz = 6'd0;
		for (int i = 0; i < 48; i++) begin
			if (a.sig[i]) lz = 6'(47 - i);
		end
		r = a;
		r.sig = a.sig << lz;
		r.exp = a.exp - $signed({5'b0, lz});
		return r;
	endfunction

	// Round to nearest even and pack, with gradual underflow.
	function automatic logic [31:0] fp_round(input fp_raw_t a);
		logic [95:0]        ext;
		logic [47:0]        s;
		logic signed [10:0] amt;
		logic [5:0]         sh;
		logic [23:0]        mant;
		logic               g;
		logic               st;
		logic               up;
		logic [24:0]        m25;
		logic signed [10:0] ef;
		logic [31:0]        r;
		ext = '0;
		s = a.sig;
		amt = 11'sd1 - a.exp;
		sh = (amt > 11'sd48) ? 6'd48 : amt[5:0];
		if (a.exp <= 11'sd0) begin
			ext = {a.sig, 48'b0} >> sh;
			s = {ext[95:49], ext[48] | (|ext[47:0])};
		end
		mant = s[47:24];
		g = s[23];
		st = |s[22:0];
		up = g & (st | mant[0]);
		m25 = {1'b0, mant} + {24'b0, up};
		ef = a.exp + $signed({10'b0, m25[24]});
		if (a.is_nan) begin
			r = FP_QNAN;
		end else if (a.is_inf) begin
			r = {a.sign, 8'hFF, 23'b0};
		end else if (a.sig == 48'd0) begin
			r = {a.sign, 31'b0};
		end else if (a.exp <= 11'sd0) begin
			r = {a.sign, 7'b0, m25[23], m25[22:0]};
		end else if (ef >= 11'sd255) begin
			r = {a.sign, 8'hFF, 23'b0};
		end else begin
			r = {a.sign, ef[7:0], m25[22:0]};
		end
		return r;
	endfunction

	// Ordered less-than; false whenever either side is NaN.
	function automatic logic fp_lt(input logic [31:0] a, input logic [31:0] b);
		logic r;
		if (((&a[30:23]) & (|a[22:0])) | ((&b[30:23]) & (|b[22:0]))) begin
			r = 1'b0;
		end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
			r = 1'b0;
		end else if (a[31] != b[31]) begin
			r = a[31];
		end else if (!a[31]) begin
			r = a[30:0] < b[30:0];
		end else begin
			r = a[30:0] > b[30:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> sv/rtic_fpu.sv
`default_nettype none

module rtic_fpu (
	input  logic              clk,
	input  rtic_pkg::fop_t    op,
	input  logic [31:0]       a,
	input  logic [31:0]       b,
	output logic [31:0]       y
);
	import rtic_pkg::*;

	fp_unp_t     ua;
	fp_unp_t     ub;
	fp_unp_t     ux;
	fp_unp_t     uy;
	logic [7:0]  dexp;
	logic [5:0]  dcl;
	logic [47:0] xs;
	logic [95:0] ext;
	logic [47:0] ys;
	logic [47:0] sum;
	fp_raw_t     raw_mul;
	fp_raw_t     raw_add;
	fp_raw_t     raw;
	fp_raw_t     raw_s1;
	fp_raw_t     norm_s2;
	logic [31:0] y_s3;

	// Multiply: full mantissa product, exponent sum.
	always_comb begin
		ua = fp_unpack(a);
		ub = fp_unpack(b);
		raw_mul.sign   = ua.sign ^ ub.sign;
		raw_mul.is_nan = ua.is_nan | ub.is_nan | (ua.is_inf & ub.is_zero) |
			(ub.is_inf & ua.is_zero);
		raw_mul.is_inf = ua.is_inf | ub.is_inf;
		raw_mul.exp    = $signed({3'b0, ua.exp}) + $signed({3'b0, ub.exp}) - 11'sd126;
		raw_mul.sig    = ua.mant * ub.mant;
	end

	// Add: order by magnitude, align the smaller operand with a sticky bit.
	always_comb begin
		if ({ua.exp, ua.mant} >= {ub.exp, ub.mant}) begin
			ux = ua;
			uy = ub;
		end else begin
			ux = ub;
			uy = ua;
		end
		dexp = ux.exp - uy.exp;
		dcl = (dexp > 8'd48) ? 6'd48 : dexp[5:0];
		xs = {1'b0, ux.mant, 23'b0};
		ext = {1'b0, uy.mant, 23'b0, 48'b0} >> dcl;
		ys = {ext[95:49], ext[48] | (|ext[47:0])};
		sum = (ux.sign == uy.sign) ? (xs + ys) : (xs - ys);
		raw_add.is_nan = ua.is_nan | ub.is_nan | (ua.is_inf & ub.is_inf & (ua.sign != ub.sign));
		raw_add.is_inf = ua.is_inf | ub.is_inf;
		if (ua.is_inf | ub.is_inf) begin
			raw_add.sign = ua.is_inf ? ua.sign : ub.sign;
		end else if (sum == 48'd0) begin
			raw_add.sign = ua.sign & ub.sign;
		end else begin
			raw_add.sign = ux.sign;
		end
		raw_add.exp = $signed({3'b0, ux.exp}) + 11'sd1;
		raw_add.sig = sum;
	end

	always_comb begin
		case (op)
			FOP_MUL: raw = raw_mul;
			FOP_ADD: raw = raw_add;
			default: raw = raw_add;
		endcase
	end

	// Three stages: core operation, normalize, round.
	always_ff @(posedge clk) begin
		raw_s1  <= raw;
		norm_s2 <= fp_normalize(raw_s1);
		y_s3    <= fp_round(norm_s2);
	end

	assign y = y_s3;

endmodule

`default_nettype wire

>>> sv/rtic_fdiv.sv
`default_nettype none

module rtic_fdiv (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] y
);
	import rtic_pkg::*;

	typedef struct packed {
		logic               sign;
		logic               is_nan;
		logic               is_inf;
		logic               is_zero;
		logic signed [10:0] exp;
	} div_meta_t;

	fp_unp_t                ua;
	fp_unp_t                ub;
	logic [4:0]             lza;
	logic [4:0]             lzb;
	div_meta_t              meta_s [DIV_STEPS+1];
	logic [24:0]            rem_s  [DIV_STEPS+1];
	logic [23:0]            dvs_s  [DIV_STEPS+1];
	logic [DIV_STEPS-1:0]   quo_s  [DIV_STEPS+1];
	logic                   ge     [DIV_STEPS];
	logic [24:0]            dif    [DIV_STEPS];
	fp_raw_t                raw;
	fp_raw_t                norm_s;
	logic [31:0]            y_s;

	// Unpack and bring subnormal mantissas up to a leading one.
	always_comb begin
		ua = fp_unpack(a);
		ub = fp_unpack(b);
		lza = 5'd0;
		lzb = 5'd0;
		for (int i = 0; i < 24; i++) begin
			if (ua.mant[i]) lza = 5'(23 - i);
			if (ub.mant[i]) lzb = 5'(23 - i);
		end
	end

	// One restoring quotient bit per stage.
	always_comb begin
		for (int k = 0; k < DIV_STEPS; k++) begin
			ge[k]  = rem_s[k] >= {1'b0, dvs_s[k]};
			dif[k] = ge[k] ? (rem_s[k] - {1'b0, dvs_s[k]}) : rem_s[k];
		end
	end

	always_ff @(posedge clk) begin
		meta_s[0].sign    <= ua.sign ^ ub.sign;
		meta_s[0].is_nan  <= ua.is_nan | ub.is_nan | (ua.is_zero & ub.is_zero) |
			(ua.is_inf & ub.is_inf);
		meta_s[0].is_inf  <= ua.is_inf | ub.is_zero;
		meta_s[0].is_zero <= ua.is_zero | ub.is_inf;
		meta_s[0].exp     <= $signed({3'b0, ua.exp}) - $signed({6'b0, lza}) -
			$signed({3'b0, ub.exp}) + $signed({6'b0, lzb}) + 11'sd127;
		rem_s[0] <= {1'b0, ua.mant << lza};
		dvs_s[0] <= ub.mant << lzb;
		quo_s[0] <= '0;
		for (int k = 0; k < DIV_STEPS; k++) begin
			meta_s[k+1] <= meta_s[k];
			dvs_s[k+1]  <= dvs_s[k];
			rem_s[k+1]  <= {dif[k][23:0], 1'b0};
			quo_s[k+1]  <= {quo_s[k][DIV_STEPS-2:0], ge[k]};
		end
		norm_s <= fp_normalize(raw);
		y_s    <= fp_round(norm_s);
	end

	// Quotient bits on top, remainder as sticky below them.
	always_comb begin
		raw.sign   = meta_s[DIV_STEPS].sign;
		raw.is_nan = meta_s[DIV_STEPS].is_nan;
		raw.is_inf = meta_s[DIV_STEPS].is_inf;
		raw.exp    = meta_s[DIV_STEPS].exp;
		raw.sig    = meta_s[DIV_STEPS].is_zero ? 48'd0 :
			{quo_s[DIV_STEPS], |rem_s[DIV_STEPS], {DIV_PAD{1'b0}}};
	end

	assign y = y_s;

endmodule

`default_nettype wire

>>> sv/ray_triangle_intersect.sv
`default_nettype none

// Ray against one triangle, binary32 throughout.
// Configuration: write the transform rows and the face normal through
// cfg_valid/cfg_ready/cfg_index/cfg_data while no ray is in flight; cfg_ready
// is always high and an unknown index is dropped.
// Rays: a request is taken on every clock edge with start high; busy stays
// low, so one ray per cycle is sustained.
// Results: done pulses for one cycle with the result on rsp. Results leave in
// request order. The dependent path runs through twelve three-stage adders
// and multipliers plus the thirty-stage divider that forms t (one quotient bit
// per stage, then normalize and round), followed by the result register.
// Reset clears the configuration registers to zero and drops every request
// in flight; no result appears for them.
// The receiver cannot stall: a result is gone after its done cycle.
module ray_triangle_intersect (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  rtic_pkg::ray_req_t                  req,
	output logic                                done,
	output rtic_pkg::hit_rsp_t                  rsp,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rtic_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [63:0]                         cfg_data
);
	import rtic_pkg::*;

	logic [63:0] row_ab_q [3];
	logic [63:0] row_cd_q [3];
	logic [63:0] nrm_xy_q;
	logic [31:0] nrm_z_q;
	logic [31:0] m [3][4];
	logic [31:0] nrm [3];
	logic [31:0] org [3];
	logic [31:0] dir [3];

	logic [31:0] pa_dz [3];
	logic [31:0] pa_oz [3];
	logic [31:0] pa_cs [3];
	logic [31:0] sb_dz, sb_oz, sb_cs;
	logic [31:0] dz, oz1, cs, oz, t;
	logic [31:0] st [3];
	logic [31:0] pt [3];
	logic [31:0] pu [3];
	logic [31:0] pv [3];
	logic [31:0] su1, sv1, su2, sv2, u, v, w1, w;
	logic        hit_a;
	logic        fin_hit;

	logic [31:0] dz2_q [FPU_LAT];
	logic [31:0] oz2_q [FPU_LAT];
	logic [31:0] cs2_q [FPU_LAT];
	logic [31:0] dzd_q [FPU_LAT];
	logic [31:0] pu2_q [FPU_LAT];
	logic [31:0] pv2_q [FPU_LAT];
	logic [31:0] org_q [3][T_T+FPU_LAT];
	logic [31:0] dir_q [3][T_T];
	logic [31:0] tmax_q [T_T];
	logic        dzz_q [T_T-T_DZ];
	logic [31:0] t_q [8*FPU_LAT];
	logic        hita_q [8*FPU_LAT];
	logic [31:0] pt_q [3][6*FPU_LAT];
	logic [31:0] u_q [2*FPU_LAT];
	logic [31:0] v_q [2*FPU_LAT];
	logic [31:0] cs_q [T_F-T_DZ];
	logic        vld_q [T_F];
	logic        done_q;
	hit_rsp_t    rsp_q;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				row_ab_q[r] <= '0;
				row_cd_q[r] <= '0;
			end
			nrm_xy_q <= '0;
			nrm_z_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ROW0_AB:   row_ab_q[0] <= cfg_data;
				REG_ROW0_CD:   row_cd_q[0] <= cfg_data;
				REG_ROW1_AB:   row_ab_q[1] <= cfg_data;
				REG_ROW1_CD:   row_cd_q[1] <= cfg_data;
				REG_ROW2_AB:   row_ab_q[2] <= cfg_data;
				REG_ROW2_CD:   row_cd_q[2] <= cfg_data;
				REG_NORMAL_XY: nrm_xy_q <= cfg_data;
				REG_NORMAL_Z:  nrm_z_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			m[r][0] = row_ab_q[r][31:0];
			m[r][1] = row_ab_q[r][63:32];
			m[r][2] = row_cd_q[r][31:0];
			m[r][3] = row_cd_q[r][63:32];
		end
		nrm[0] = nrm_xy_q[31:0];
		nrm[1] = nrm_xy_q[63:32];
		nrm[2] = nrm_z_q;
		org[0] = req.origin_x;
		org[1] = req.origin_y;
		org[2] = req.origin_z;
		dir[0] = req.dir_x;
		dir[1] = req.dir_y;
		dir[2] = req.dir_z;
	end

	// Products against row 2 and the normal.
	for (genvar i = 0; i < 3; i++) begin : g_pa
		rtic_fpu u_mdz (.clk(clk), .op(FOP_MUL), .a(m[2][i]), .b(dir[i]), .y(pa_dz[i]));
		rtic_fpu u_moz (.clk(clk), .op(FOP_MUL), .a(m[2][i]), .b(org[i]), .y(pa_oz[i]));
		rtic_fpu u_mcs (.clk(clk), .op(FOP_MUL), .a(nrm[i]), .b(dir[i]), .y(pa_cs[i]));
	end

	// Dot products summed left to right.
	rtic_fpu u_adz1 (.clk(clk), .op(FOP_ADD), .a(pa_dz[0]), .b(pa_dz[1]), .y(sb_dz));
	rtic_fpu u_aoz1 (.clk(clk), .op(FOP_ADD), .a(pa_oz[0]), .b(pa_oz[1]), .y(sb_oz));
	rtic_fpu u_acs1 (.clk(clk), .op(FOP_ADD), .a(pa_cs[0]), .b(pa_cs[1]), .y(sb_cs));
	rtic_fpu u_adz2 (.clk(clk), .op(FOP_ADD), .a(sb_dz), .b(dz2_q[FPU_LAT-1]), .y(dz));
	rtic_fpu u_aoz2 (.clk(clk), .op(FOP_ADD), .a(sb_oz), .b(oz2_q[FPU_LAT-1]), .y(oz1));
	rtic_fpu u_acs2 (.clk(clk), .op(FOP_ADD), .a(sb_cs), .b(cs2_q[FPU_LAT-1]), .y(cs));
	rtic_fpu u_aoz3 (.clk(clk), .op(FOP_ADD), .a(oz1), .b(m[2][3]), .y(oz));

	// Distance along the ray.
	rtic_fdiv u_div (
		.clk(clk),
		.a({~oz[31], oz[30:0]}),
		.b(dzd_q[FPU_LAT-1]),
		.y(t)
	);

	assign hit_a = ~dzz_q[T_T-T_DZ-1] & fp_lt(FP_ZERO, t) & fp_lt(t, tmax_q[T_T-1]);

	// Hit point and its row 0 and row 1 products.
	for (genvar i = 0; i < 3; i++) begin : g_pt
		rtic_fpu u_mst (.clk(clk), .op(FOP_MUL), .a(t), .b(dir_q[i][T_T-1]), .y(st[i]));
		rtic_fpu u_apt (.clk(clk), .op(FOP_ADD), .a(org_q[i][T_T+FPU_LAT-1]), .b(st[i]),
			.y(pt[i]));
		rtic_fpu u_mpu (.clk(clk), .op(FOP_MUL), .a(m[0][i]), .b(pt[i]), .y(pu[i]));
		rtic_fpu u_mpv (.clk(clk), .op(FOP_MUL), .a(m[1][i]), .b(pt[i]), .y(pv[i]));
	end

	// Barycentric sums and w = 1 - (u + v).
	rtic_fpu u_au1 (.clk(clk), .op(FOP_ADD), .a(pu[0]), .b(pu[1]), .y(su1));
	rtic_fpu u_av1 (.clk(clk), .op(FOP_ADD), .a(pv[0]), .b(pv[1]), .y(sv1));
	rtic_fpu u_au2 (.clk(clk), .op(FOP_ADD), .a(su1), .b(pu2_q[FPU_LAT-1]), .y(su2));
	rtic_fpu u_av2 (.clk(clk), .op(FOP_ADD), .a(sv1), .b(pv2_q[FPU_LAT-1]), .y(sv2));
	rtic_fpu u_au3 (.clk(clk), .op(FOP_ADD), .a(su2), .b(m[0][3]), .y(u));
	rtic_fpu u_av3 (.clk(clk), .op(FOP_ADD), .a(sv2), .b(m[1][3]), .y(v));
	rtic_fpu u_aw1 (.clk(clk), .op(FOP_ADD), .a(u), .b(v), .y(w1));
	rtic_fpu u_aw2 (.clk(clk), .op(FOP_ADD), .a(FP_ONE), .b({~w1[31], w1[30:0]}), .y(w));

	// Delay lines that keep operands aligned with the arithmetic pipeline.
	always_ff @(posedge clk) begin
		dz2_q[0]  <= pa_dz[2];
		oz2_q[0]  <= pa_oz[2];
		cs2_q[0]  <= pa_cs[2];
		dzd_q[0]  <= dz;
		pu2_q[0]  <= pu[2];
		pv2_q[0]  <= pv[2];
		for (int i = 1; i < FPU_LAT; i++) begin
			dz2_q[i] <= dz2_q[i-1];
			oz2_q[i] <= oz2_q[i-1];
			cs2_q[i] <= cs2_q[i-1];
			dzd_q[i] <= dzd_q[i-1];
			pu2_q[i] <= pu2_q[i-1];
			pv2_q[i] <= pv2_q[i-1];
		end
		for (int j = 0; j < 3; j++) begin
			org_q[j][0] <= org[j];
			for (int i = 1; i < T_T + FPU_LAT; i++) org_q[j][i] <= org_q[j][i-1];
			dir_q[j][0] <= dir[j];
			for (int i = 1; i < T_T; i++) dir_q[j][i] <= dir_q[j][i-1];
			pt_q[j][0] <= pt[j];
			for (int i = 1; i < 6 * FPU_LAT; i++) pt_q[j][i] <= pt_q[j][i-1];
		end
		tmax_q[0] <= req.t_max;
		for (int i = 1; i < T_T; i++) tmax_q[i] <= tmax_q[i-1];
		dzz_q[0] <= (dz[30:0] == 31'd0);
		for (int i = 1; i < T_T - T_DZ; i++) dzz_q[i] <= dzz_q[i-1];
		t_q[0]    <= t;
		hita_q[0] <= hit_a;
		for (int i = 1; i < 8 * FPU_LAT; i++) begin
			t_q[i]    <= t_q[i-1];
			hita_q[i] <= hita_q[i-1];
		end
		u_q[0] <= u;
		v_q[0] <= v;
		for (int i = 1; i < 2 * FPU_LAT; i++) begin
			u_q[i] <= u_q[i-1];
			v_q[i] <= v_q[i-1];
		end
		cs_q[0] <= cs;
		for (int i = 1; i < T_F - T_DZ; i++) cs_q[i] <= cs_q[i-1];
	end

	// Request valid bits travel alongside the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < T_F; i++) vld_q[i] <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_q[0] <= start && !busy;
			for (int i = 1; i < T_F; i++) vld_q[i] <= vld_q[i-1];
			done_q <= vld_q[T_F-1];
		end
	end

	// Final inside test and result register; a miss reports all zeros.
	assign fin_hit = hita_q[8*FPU_LAT-1] & fp_lt(FP_ZERO, u_q[2*FPU_LAT-1]) &
		fp_lt(FP_ZERO, v_q[2*FPU_LAT-1]) & fp_lt(FP_ZERO, w);

	always_ff @(posedge clk) begin
		rsp_q.hit       <= fin_hit;
		rsp_q.t_hit     <= fin_hit ? t_q[8*FPU_LAT-1] : FP_ZERO;
		rsp_q.point_x   <= fin_hit ? pt_q[0][6*FPU_LAT-1] : FP_ZERO;
		rsp_q.point_y   <= fin_hit ? pt_q[1][6*FPU_LAT-1] : FP_ZERO;
		rsp_q.point_z   <= fin_hit ? pt_q[2][6*FPU_LAT-1] : FP_ZERO;
		rsp_q.bary_u    <= fin_hit ? u_q[2*FPU_LAT-1] : FP_ZERO;
		rsp_q.bary_v    <= fin_hit ? v_q[2*FPU_LAT-1] : FP_ZERO;
		rsp_q.back_face <= fin_hit & fp_lt(FP_ZERO, cs_q[T_F-T_DZ-1]);
	end

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign rsp       = rsp_q;

	`include "assert_macros.svh"

	// A hit lies strictly ahead of the origin.
	`ASSERT_IMP(a_hit_t_pos, done && rsp.hit, !rsp.t_hit[31] && (rsp.t_hit[30:0] != 31'd0), "hit with non-positive t")
	// A hit has non-negative barycentric u and v.
	`ASSERT_IMP(a_hit_bary_pos, done && rsp.hit, !rsp.bary_u[31] && !rsp.bary_v[31], "hit with negative barycentric")
	// A miss reports neither distance nor face.
	`ASSERT_IMP(a_miss_clear, done && !rsp.hit, (rsp.t_hit == 32'd0) && !rsp.back_face, "miss with nonzero fields")

endmodule

`default_nettype wire

>>> test/tb_ray_triangle_intersect.sv
`timescale 1ns / 100ps

module tb_ray_triangle_intersect;
	import rtic_pkg::*;

	localparam int DRAIN_CYCLES = 80;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES = 6;
	localparam int RAYS_PER_PHASE = 225;
	localparam logic [7:0] BAD_INDEX = 8'd8;
	localparam logic [7:0] TOP_INDEX = 8'hFF;
	localparam logic [31:0] F_INF = 32'h7F80_0000;
	localparam logic [31:0] F_MAX = 32'h7F7F_FFFF;

	typedef struct {
		ray_req_t  ray;
		bit        typed;
		hit_rsp_t  want;
	} ray_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	ray_req_t req;
	logic done;
	hit_rsp_t rsp;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [63:0] cfg_data;

	// Expectation tagging for the directed rows, driven alongside each request.
	bit cur_typed;
	hit_rsp_t cur_want;

	logic [63:0] tri_regs [8];
	hit_rsp_t pending_hits [$];
	ray_row_t directed_rows [$];
	int mismatches;
	int cycles;

	// Current triangle placement for building rays that aim at it.
	real k0, k1, k2, b0, b1, b2;

	ray_triangle_intersect u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Binary32 pattern to an exact double.
	function automatic real f2r(input logic [31:0] b);
		logic [7:0] e;
		logic [22:0] m;
		real r;
		e = b[30:23];
		m = b[22:0];
		if (e == 8'hFF) begin
			return $bitstoreal({b[31], 11'h7FF, (m != 0) ? 52'h8_0000_0000_0000 : 52'h0});
		end
		if (e == 8'h00) begin
			if (m == 0) return $bitstoreal({b[31], 63'b0});
			r = real'(m) * $bitstoreal(64'h36A0_0000_0000_0000);
			return b[31] ? -r : r;
		end
		return $bitstoreal({b[31], {3'b0, e} + 11'd896, m, 29'b0});
	endfunction

	// Double to binary32, round to nearest even with gradual underflow.
	function automatic logic [31:0] r2f(input real r);
		logic [63:0] d;
		logic [63:0] sig;
		logic [63:0] kept;
		logic g;
		logic st;
		int fe;
		int sh;
		d = $realtobits(r);
		if (d[62:52] == 11'h7FF) return (d[51:0] != 0) ? 32'h7FC0_0000 : {d[63], F_INF[30:0]};
		if (d[62:52] == 11'h000) return {d[63], 31'b0};
		sig = {11'b0, 1'b1, d[51:0]};
		fe = int'(d[62:52]) - 1023 + 127;
		sh = (fe >= 1) ? 29 : 30 - fe;
		if (sh > 60) sh = 60;
		kept = sig >> sh;
		g = sig[sh-1];
		st = (sig & ((64'd1 << (sh - 1)) - 64'd1)) != 0;
		kept = kept + {63'b0, g & (st | kept[0])};
		if (fe >= 1) begin
			if (kept[24]) begin
				kept = kept >> 1;
				fe++;
			end
			if (fe >= 255) return {d[63], F_INF[30:0]};
			return {d[63], 8'(fe), kept[22:0]};
		end
		return {d[63], kept[30:0]};
	endfunction

	// Each operation is computed in double precision and the result rounded to binary32.
	function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
		return r2f(f2r(a) * f2r(b));
	endfunction

	function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
		return r2f(f2r(a) + f2r(b));
	endfunction

	function automatic logic [31:0] fdiv(input logic [31:0] a, input logic [31:0] b);
		return r2f(f2r(a) / f2r(b));
	endfunction

	function automatic logic [31:0] fneg(input logic [31:0] a);
		return {~a[31], a[30:0]};
	endfunction

	function automatic logic is_nan(input logic [31:0] a);
		return (a[30:23] == 8'hFF) && (a[22:0] != 0);
	endfunction

	// Ordered compare through a monotonic integer key; NaN compares false.
	function automatic logic [31:0] order_key(input logic [31:0] a);
		if (a[30:0] == 0) return 32'h8000_0000;
		return a[31] ? ~a : (a | 32'h8000_0000);
	endfunction

	function automatic logic flt(input logic [31:0] a, input logic [31:0] b);
		if (is_nan(a) || is_nan(b)) return 1'b0;
		return order_key(a) < order_key(b);
	endfunction

	function automatic logic [31:0] dot3(input logic [31:0] a, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z);
		return fadd(fadd(fmul(a, x), fmul(b, y)), fmul(c, z));
	endfunction

	// Expected outcome of one ray against the currently loaded triangle.
	function automatic hit_rsp_t trace_ray(input ray_req_t r);
		hit_rsp_t res;
		logic [31:0] dz, oz, t, px, py, pz, u, v, w, cs;
		res = '0;
		dz = dot3(tri_regs[4][31:0], tri_regs[4][63:32], tri_regs[5][31:0],
			r.dir_x, r.dir_y, r.dir_z);
		if (dz[30:0] == 0) return res;
		oz = fadd(dot3(tri_regs[4][31:0], tri_regs[4][63:32], tri_regs[5][31:0],
			r.origin_x, r.origin_y, r.origin_z), tri_regs[5][63:32]);
		t = fdiv(fneg(oz), dz);
		if (!(flt(FP_ZERO, t) && flt(t, r.t_max))) return res;
		px = fadd(r.origin_x, fmul(t, r.dir_x));
		py = fadd(r.origin_y, fmul(t, r.dir_y));
		pz = fadd(r.origin_z, fmul(t, r.dir_z));
		u = fadd(dot3(tri_regs[0][31:0], tri_regs[0][63:32], tri_regs[1][31:0],
			px, py, pz), tri_regs[1][63:32]);
		v = fadd(dot3(tri_regs[2][31:0], tri_regs[2][63:32], tri_regs[3][31:0],
			px, py, pz), tri_regs[3][63:32]);
		w = fadd(FP_ONE, fneg(fadd(u, v)));
		if (!(flt(FP_ZERO, u) && flt(FP_ZERO, v) && flt(FP_ZERO, w))) return res;
		cs = dot3(tri_regs[6][31:0], tri_regs[6][63:32], tri_regs[7][31:0],
			r.dir_x, r.dir_y, r.dir_z);
		res.hit = 1'b1;
		res.t_hit = t;
		res.point_x = px;
		res.point_y = py;
		res.point_z = pz;
		res.bary_u = u;
		res.bary_v = v;
		res.back_face = flt(FP_ZERO, cs);
		return res;
	endfunction

	// Track register writes and queue the expectation for each accepted request.
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready && cfg_index < BAD_INDEX) begin
			tri_regs[cfg_index] = (cfg_index == REG_NORMAL_Z) ? {32'b0, cfg_data[31:0]} : cfg_data;
		end
		if (arst_n && start && !busy) begin
			pending_hits.push_back(cur_typed ? cur_want : trace_ray(req));
		end
	end

	// Compare each result with the oldest expectation.
	always @(posedge clk) begin
		hit_rsp_t want;
		if (arst_n && done) begin
			if (pending_hits.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", rsp);
			end else begin
				want = pending_hits.pop_front();
				if (rsp.hit !== want.hit || rsp.t_hit !== want.t_hit ||
						rsp.point_x !== want.point_x || rsp.point_y !== want.point_y ||
						rsp.point_z !== want.point_z || rsp.bary_u !== want.bary_u ||
						rsp.bary_v !== want.bary_v || rsp.back_face !== want.back_face) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: hit %b/%b t %h/%h p %h %h %h / %h %h %h",
							rsp.hit, want.hit, rsp.t_hit, want.t_hit, rsp.point_x,
							rsp.point_y, rsp.point_z, want.point_x, want.point_y,
							want.point_z);
						$display("  u %h/%h v %h/%h back %b/%b", rsp.bary_u, want.bary_u,
							rsp.bary_v, want.bary_v, rsp.back_face, want.back_face);
					end
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_ray_triangle_intersect: errors");
			$finish;
		end
	end

	function automatic real rnd(input real lo, input real hi);
		return lo + (hi - lo) * (real'($urandom) / 4294967296.0);
	endfunction

	task automatic write_reg(input logic [7:0] idx, input logic [63:0] val, input bit idle_ok);
		if (idle_ok && $urandom_range(0, 2) == 0) repeat ($urandom_range(1, 19)) @(posedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_ray(input ray_req_t r, input bit typed, input hit_rsp_t w);
		req <= r;
		cur_typed <= typed;
		cur_want <= w;
		start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	task automatic maybe_idle(input bit idle_ok);
		if (idle_ok && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
	endtask

	// Let every request in flight come back before touching the registers.
	task automatic wait_idle();
		start <= 1'b0;
		@(posedge clk);
		while (pending_hits.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Triangle with u = k0*x + b0, v = k1*y + b1 in the plane k2*z + b2 = 0.
	task automatic load_plane(input bit idle_ok);
		write_reg(REG_ROW0_AB, {32'b0, r2f(k0)}, idle_ok);
		write_reg(REG_ROW0_CD, {r2f(b0), 32'b0}, idle_ok);
		write_reg(REG_ROW1_AB, {r2f(k1), 32'b0}, idle_ok);
		write_reg(REG_ROW1_CD, {r2f(b1), 32'b0}, idle_ok);
		write_reg(REG_ROW2_AB, 64'b0, idle_ok);
		write_reg(REG_ROW2_CD, {r2f(b2), r2f(k2)}, idle_ok);
		write_reg(REG_NORMAL_XY, {r2f(rnd(-1.0, 1.0)), r2f(rnd(-1.0, 1.0))}, idle_ok);
		write_reg(REG_NORMAL_Z, {$urandom, r2f(rnd(-1.0, 1.0))}, idle_ok);
	endtask

	// Mostly rays aimed into the triangle, plus edge cases and raw noise.
	function automatic ray_req_t make_ray();
		ray_req_t r;
		int pick;
		real u, v, tx, ty, tz, ox, oy, oz, sc;
		pick = $urandom_range(0, 99);
		if (pick < 15) begin
			r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
			return r;
		end
		u = rnd(0.0, 1.0);
		v = rnd(0.0, 1.0 - u);
		if (pick < 20) u = 0.0;
		else if (pick < 25) v = 1.0 - u;
		tx = (u - b0) / k0;
		ty = (v - b1) / k1;
		tz = -b2 / k2;
		ox = rnd(-20.0, 20.0);
		oy = rnd(-20.0, 20.0);
		oz = rnd(-20.0, 20.0);
		sc = rnd(0.1, 4.0);
		r.origin_x = r2f(ox);
		r.origin_y = r2f(oy);
		r.origin_z = r2f(oz);
		r.dir_x = r2f((tx - ox) * sc);
		r.dir_y = r2f((ty - oy) * sc);
		r.dir_z = r2f((tz - oz) * sc);
		if (pick < 35) r.t_max = r2f(rnd(0.0, 2.0));
		else if (pick < 40) r.t_max = F_INF;
		else r.t_max = r2f(1.0e6);
		return r;
	endfunction

	function automatic ray_req_t ray_of(input logic [31:0] ox, input logic [31:0] oy,
			input logic [31:0] oz, input logic [31:0] dx, input logic [31:0] dy,
			input logic [31:0] dz, input logic [31:0] tm);
		ray_req_t r;
		r = {ox, oy, oz, dx, dy, dz, tm};
		return r;
	endfunction

	task automatic add_row(input ray_req_t r, input bit typed, input hit_rsp_t w);
		ray_row_t row;
		row.ray = r;
		row.typed = typed;
		row.want = w;
		directed_rows.push_back(row);
	endtask

	initial begin
		hit_rsp_t miss;
		hit_rsp_t plain_hit;
		ray_req_t r;
		bit idle_ok;
		int zero_rows;

		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cur_typed = 1'b0;
		cur_want = '0;
		mismatches = 0;
		cycles = 0;
		foreach (tri_regs[i]) tri_regs[i] = '0;

		miss = '0;
		plain_hit = '{1'b1, 32'h40A0_0000, 32'h3E80_0000, 32'h3E80_0000, 32'h40A0_0000,
			32'h3E80_0000, 32'h3E80_0000, 1'b1};

		// Cleared registers: every ray is parallel to the zero plane.
		add_row('0, 1, miss);
		add_row('1, 1, miss);
		add_row(ray_of(F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, F_MAX), 1, miss);
		add_row(ray_of(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1, miss);
		zero_rows = directed_rows.size();

		// Unit triangle in the plane z = 5 with the normal along +z.
		add_row(ray_of(32'h3E80_0000, 32'h3E80_0000, 0, 0, 0, FP_ONE, 32'h42C8_0000), 1,
			plain_hit);
		add_row(ray_of(32'h3E80_0000, 32'h3E80_0000, 0, FP_ONE, 0, 0, 32'h42C8_0000), 1, miss);
		add_row(ray_of(32'h3E80_0000, 32'h3E80_0000, 0, 32'hBF80_0000, 32'hBF80_0000,
			32'h8000_0000, 32'h42C8_0000), 1, miss);
		add_row(ray_of(32'h3E80_0000, 32'h3E80_0000, 0, 0, 0, FP_ONE, 32'h40A0_0000), 1, miss);
		add_row(ray_of(32'h3E80_0000, 32'h3E80_0000, 0, 0, 0, 32'hBF80_0000, 32'h42C8_0000),
			1, miss);
		add_row(ray_of(32'h3E80_0000, 32'h3E80_0000, 0, 0, 0, FP_QNAN, 32'h42C8_0000), 1, miss);
		add_row(ray_of(32'h3E80_0000, 32'h3E80_0000, 0, 0, 0, F_INF, 32'h42C8_0000), 1, miss);
		add_row(ray_of(0, 32'h3E80_0000, 0, 0, 0, FP_ONE, 32'h42C8_0000), 1, miss);
		add_row(ray_of(32'h3F00_0000, 32'h3F00_0000, 0, 0, 0, FP_ONE, 32'h42C8_0000), 1, miss);
		add_row(ray_of(32'h3E80_0000, 32'h3E80_0000, 0, 0, 0, FP_ONE, 32'h7FFF_FFFF), 1, miss);
		add_row(ray_of(32'h3E80_0000, 32'h3E80_0000, 0, 0, 0, FP_ONE, F_INF), 0, miss);
		add_row(ray_of(32'h3DCC_CCCD, 32'h3E4C_CCCD, 0, 32'h3E00_0000, 0, FP_ONE,
			32'h42C8_0000), 0, miss);
		add_row(ray_of(32'h0000_0001, 32'h3E80_0000, 0, 0, 0, FP_ONE, 32'h42C8_0000), 0, miss);
		add_row(ray_of(32'h3E80_0000, 32'h3E80_0000, F_MAX, 0, 0, 32'hBF80_0000, F_INF), 0,
			miss);
		add_row(ray_of(32'h3E80_0000, 32'h3E80_0000, 0, 0, 0, 32'h0000_0001, F_INF), 0, miss);
		add_row(ray_of(32'h3E80_0000, 32'h3E80_0000, 32'h4120_0000, 32'h3D80_0000,
			32'hBD80_0000, 32'hBF80_0000, 32'h42C8_0000), 0, miss);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed rows.
		foreach (directed_rows[i]) begin
			if (i == zero_rows) begin
				wait_idle();
				write_reg(REG_ROW0_AB, {32'b0, FP_ONE}, 0);
				write_reg(REG_ROW0_CD, 64'b0, 0);
				write_reg(REG_ROW1_AB, {FP_ONE, 32'b0}, 0);
				write_reg(REG_ROW1_CD, 64'b0, 0);
				write_reg(REG_ROW2_AB, 64'b0, 0);
				write_reg(REG_ROW2_CD, {32'hC0A0_0000, FP_ONE}, 0);
				write_reg(REG_NORMAL_XY, 64'b0, 0);
				write_reg(REG_NORMAL_Z, {32'b0, FP_ONE}, 0);
			end
			send_ray(directed_rows[i].ray, directed_rows[i].typed, directed_rows[i].want);
			maybe_idle(1);
		end
		wait_idle();

		// Random phases, each under its own register setting.
		for (int p = 0; p < PHASES; p++) begin
			idle_ok = (p != PHASES - 1);
			if (p == 2) begin
				for (int i = 0; i < 8; i++) write_reg(8'(i), '1, idle_ok);
				write_reg(BAD_INDEX, 64'b0, idle_ok);
				write_reg(TOP_INDEX, 64'b0, idle_ok);
			end else if (p == 3) begin
				for (int i = 0; i < 8; i++) begin
					write_reg(8'(i), {r2f(rnd(-2.0, 2.0)), r2f(rnd(-2.0, 2.0))}, idle_ok);
				end
			end else begin
				k0 = rnd(0.2, 4.0) * (($urandom_range(0, 1) == 1) ? -1.0 : 1.0);
				k1 = rnd(0.2, 4.0) * (($urandom_range(0, 1) == 1) ? -1.0 : 1.0);
				k2 = rnd(0.2, 4.0) * (($urandom_range(0, 1) == 1) ? -1.0 : 1.0);
				b0 = rnd(-3.0, 3.0);
				b1 = rnd(-3.0, 3.0);
				b2 = rnd(-8.0, 8.0);
				load_plane(idle_ok);
			end
			for (int n = 0; n < RAYS_PER_PHASE; n++) begin
				r = make_ray();
				send_ray(r, 0, miss);
				maybe_idle(idle_ok);
			end
			wait_idle();
		end

		if (mismatches == 0) begin
			$display("tb_ray_triangle_intersect: clean");
		end else begin
			$display("tb_ray_triangle_intersect: errors");
		end
		$finish;
	end

endmodule

>>> files.f
+incdir+sv
sv/rtic_pkg.sv
sv/rtic_fpu.sv
sv/rtic_fdiv.sv
sv/ray_triangle_intersect.sv
test/tb_ray_triangle_intersect.sv
